@@ rtl/pfab_pkg.sv @@
// Package: pixel format codes, register indexes and the channel mix function.
package pfab_pkg;

	typedef enum logic [1:0] {
		FMT_565  = 2'd0,
		FMT_5551 = 2'd1,
		FMT_4444 = 2'd2,
		FMT_8888 = 2'd3
	} pixel_fmt_t;

	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 2;

	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_PIXEL_FORMAT = 1'b0;
	localparam cfg_idx_t CFG_BLEND_ENABLE = 1'b1;

	localparam logic [7:0] MAX8 = 8'hFF;
	localparam logic [7:0] MAX6 = 8'h3F;
	localparam logic [7:0] MAX5 = 8'h1F;
	localparam logic [7:0] MAX4 = 8'h0F;

	// (f*a + b*(max-a)) >> bits, masked to max
	function automatic logic [7:0] mix_channel(
		input logic [7:0] f,
		input logic [7:0] b,
		input logic [7:0] a,
		input logic [7:0] maxv,
		input logic [3:0] bits
	);
		logic [7:0]  inv;
		logic [15:0] sum;
		logic [15:0] shifted;
		inv     = maxv - a;
		sum     = ({8'h00, f} * {8'h00, a}) + ({8'h00, b} * {8'h00, inv});
		shifted = sum >> bits;
		return shifted[7:0] & maxv;
	endfunction

endpackage

@@ rtl/pixel_format_alpha_blend_top.sv @@
// Top level: pixel format conversion and alpha blend in a two-stage pipeline.
//
// Converts a 32-bit foreground color (alpha, blue, green, red from the top byte
// down) to the selected framebuffer format (565, 5551, 4444 or 8888) and, with
// blending enabled, mixes it with the current framebuffer pixel using the
// foreground alpha reduced to the format's precision. One pixel is accepted
// every clock; each result passes through the input register and then the
// result register around the three channel multiply-add paths before it is
// offered on pixel_out. A stalled output holds both stages, and the input
// stalls only when both are full. Configuration must be written while the
// pipeline is empty. 16-bit formats use the low half of bg_pixel and return
// zero in the high half of pixel_out.
module pixel_format_alpha_blend_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  pfab_pkg::cfg_idx_t         cfg_index,
	input  logic [pfab_pkg::CfgDataW-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [31:0]                fg_color,
	input  logic [31:0]                bg_pixel,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [31:0]                pixel_out
);
	import pfab_pkg::*;

	pixel_fmt_t  fmt_q;
	logic        blend_q;

	logic        valid_s1;
	logic [31:0] fg_s1;
	logic [31:0] bg_s1;
	logic        valid_s2;
	logic [31:0] pixel_s2;
	logic        ready_s2;

	logic [31:0] result;
	logic [31:0] conv_565;
	logic [31:0] conv_5551;
	logic [31:0] conv_4444;
	logic [31:0] blend_8888;
	logic [31:0] blend_565;
	logic [31:0] blend_5551;
	logic [31:0] blend_4444;
	logic [31:0] bg_low;
	logic [7:0]  a8;
	logic [7:0]  a6;
	logic [7:0]  a5;
	logic [7:0]  a565r;
	logic [7:0]  a4;
	logic [7:0]  m565_b;
	logic [7:0]  m565_g;
	logic [7:0]  m565_r;
	logic [7:0]  m5551_b;
	logic [7:0]  m5551_g;
	logic [7:0]  m5551_r;
	logic [7:0]  m4444_b;
	logic [7:0]  m4444_g;
	logic [7:0]  m4444_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_8888;
			blend_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PIXEL_FORMAT: fmt_q   <= pixel_fmt_t'(cfg_data[1:0]);
				CFG_BLEND_ENABLE: blend_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			fg_s1 <= fg_color;
			bg_s1 <= bg_pixel;
		end
		if (ready_s2 && valid_s1) begin
			pixel_s2 <= result;
		end
	end

	always_comb begin
		a8     = fg_s1[31:24];
		a6     = {2'b00, fg_s1[31:26]};
		a565r  = {3'b000, fg_s1[31:27]};
		a5     = {3'b000, fg_s1[31:27]};
		a4     = {4'b0000, fg_s1[31:28]};
		bg_low = {16'h0000, bg_s1[15:0]};

		conv_565  = {16'h0000, fg_s1[23:19], fg_s1[15:10], fg_s1[7:3]};
		conv_5551 = {16'h0000, |fg_s1[31:24], fg_s1[23:19], fg_s1[15:11], fg_s1[7:3]};
		conv_4444 = {16'h0000, fg_s1[31:28], fg_s1[23:20], fg_s1[15:12], fg_s1[7:4]};

		m565_b  = mix_channel({3'b000, fg_s1[23:19]}, {3'b000, bg_s1[15:11]}, a565r, MAX5,
			4'd5);
		m565_g  = mix_channel({2'b00, fg_s1[15:10]}, {2'b00, bg_s1[10:5]}, a6, MAX6, 4'd6);
		m565_r  = mix_channel({3'b000, fg_s1[7:3]}, {3'b000, bg_s1[4:0]}, a565r, MAX5, 4'd5);
		m5551_b = mix_channel({3'b000, fg_s1[23:19]}, {3'b000, bg_s1[14:10]}, a5, MAX5,
			4'd5);
		m5551_g = mix_channel({3'b000, fg_s1[15:11]}, {3'b000, bg_s1[9:5]}, a5, MAX5, 4'd5);
		m5551_r = mix_channel({3'b000, fg_s1[7:3]}, {3'b000, bg_s1[4:0]}, a5, MAX5, 4'd5);
		m4444_b = mix_channel({4'h0, fg_s1[23:20]}, {4'h0, bg_s1[11:8]}, a4, MAX4, 4'd4);
		m4444_g = mix_channel({4'h0, fg_s1[15:12]}, {4'h0, bg_s1[7:4]}, a4, MAX4, 4'd4);
		m4444_r = mix_channel({4'h0, fg_s1[7:4]}, {4'h0, bg_s1[3:0]}, a4, MAX4, 4'd4);

		if (a8 == 8'h00) begin
			blend_8888 = bg_s1;
		end else if (a8 == MAX8) begin
			blend_8888 = fg_s1;
		end else begin
			blend_8888 = {a8,
				mix_channel(fg_s1[23:16], bg_s1[23:16], a8, MAX8, 4'd8),
				mix_channel(fg_s1[15:8], bg_s1[15:8], a8, MAX8, 4'd8),
				mix_channel(fg_s1[7:0], bg_s1[7:0], a8, MAX8, 4'd8)};
		end

		if (a6 == 8'h00) begin
			blend_565 = bg_low;
		end else if (a6 == MAX6) begin
			blend_565 = conv_565;
		end else begin
			blend_565 = {16'h0000, m565_b[4:0], m565_g[5:0], m565_r[4:0]};
		end

		if (a5 == 8'h00) begin
			blend_5551 = bg_low;
		end else if (a5 == MAX5) begin
			blend_5551 = conv_5551;
		end else begin
			blend_5551 = {16'h0000, 1'b1, m5551_b[4:0], m5551_g[4:0], m5551_r[4:0]};
		end

		if (a4 == 8'h00) begin
			blend_4444 = bg_low;
		end else if (a4 == MAX4) begin
			blend_4444 = conv_4444;
		end else begin
			blend_4444 = {16'h0000, fg_s1[31:28], m4444_b[3:0], m4444_g[3:0], m4444_r[3:0]};
		end

		case (fmt_q)
			FMT_565:  result = blend_q ? blend_565 : conv_565;
			FMT_5551: result = blend_q ? blend_5551 : conv_5551;
			FMT_4444: result = blend_q ? blend_4444 : conv_4444;
			default:  result = blend_q ? blend_8888 : fg_s1;
		endcase
	end

	assign out_valid = valid_s2;
	assign pixel_out = pixel_s2;

endmodule

@@ tb/pfab_checker.sv @@
// Checker: mirrors the config registers, predicts each output pixel and compares beats in order.
`timescale 1ns / 100ps

module pfab_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  pfab_pkg::cfg_idx_t            cfg_index,
	input  logic [pfab_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [31:0]                   fg_color,
	input  logic [31:0]                   bg_pixel,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [31:0]                   pixel_out,
	output int                            mismatches,
	output int                            pending
);
	import pfab_pkg::*;

	pixel_fmt_t  cur_fmt;
	logic        cur_blend;
	logic [31:0] pixel_queue [$];
	int          fail_total;

	assign mismatches = fail_total;

	function automatic logic [7:0] blend_channel(
		input logic [7:0]  f,
		input logic [7:0]  b,
		input logic [7:0]  a,
		input logic [7:0]  top,
		input int unsigned shift
	);
		logic [31:0] sum;
		sum = ({24'h0, f} * {24'h0, a}) + ({24'h0, b} * ({24'h0, top} - {24'h0, a}));
		return 8'((sum >> shift) & {24'h0, top});
	endfunction

	function automatic logic [15:0] pack_565(input logic [31:0] c);
		return {c[23:19], c[15:10], c[7:3]};
	endfunction

	function automatic logic [15:0] pack_5551(input logic [31:0] c);
		return {|c[31:24], c[23:19], c[15:11], c[7:3]};
	endfunction

	function automatic logic [15:0] pack_4444(input logic [31:0] c);
		return {c[31:28], c[23:20], c[15:12], c[7:4]};
	endfunction

	function automatic logic [31:0] expected_pixel(
		input pixel_fmt_t  fmt,
		input logic        blend_on,
		input logic [31:0] fg,
		input logic [31:0] bg
	);
		logic [15:0] f16;
		logic [15:0] b16;
		logic [7:0]  a;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  bl;
		b16 = bg[15:0];
		if (!blend_on) begin
			case (fmt)
				FMT_565:  return {16'h0, pack_565(fg)};
				FMT_5551: return {16'h0, pack_5551(fg)};
				FMT_4444: return {16'h0, pack_4444(fg)};
				default:  return fg;
			endcase
		end
		case (fmt)
			FMT_565: begin
				a   = {2'b00, fg[31:26]};
				f16 = pack_565(fg);
				if (a == 8'h00) return {16'h0, b16};
				if (a == 8'h3F) return {16'h0, f16};
				r  = blend_channel({3'b000, f16[4:0]}, {3'b000, b16[4:0]}, a >> 1, 8'h1F, 5);
				g  = blend_channel({2'b00, f16[10:5]}, {2'b00, b16[10:5]}, a, 8'h3F, 6);
				bl = blend_channel({3'b000, f16[15:11]}, {3'b000, b16[15:11]}, a >> 1,
					8'h1F, 5);
				return {16'h0, bl[4:0], g[5:0], r[4:0]};
			end
			FMT_5551: begin
				a   = {3'b000, fg[31:27]};
				f16 = pack_5551(fg);
				if (a == 8'h00) return {16'h0, b16};
				if (a == 8'h1F) return {16'h0, f16};
				r  = blend_channel({3'b000, f16[4:0]}, {3'b000, b16[4:0]}, a, 8'h1F, 5);
				g  = blend_channel({3'b000, f16[9:5]}, {3'b000, b16[9:5]}, a, 8'h1F, 5);
				bl = blend_channel({3'b000, f16[14:10]}, {3'b000, b16[14:10]}, a, 8'h1F, 5);
				return {16'h0, 1'b1, bl[4:0], g[4:0], r[4:0]};
			end
			FMT_4444: begin
				a   = {4'h0, fg[31:28]};
				f16 = pack_4444(fg);
				if (a == 8'h00) return {16'h0, b16};
				if (a == 8'h0F) return {16'h0, f16};
				r  = blend_channel({4'h0, f16[3:0]}, {4'h0, b16[3:0]}, a, 8'h0F, 4);
				g  = blend_channel({4'h0, f16[7:4]}, {4'h0, b16[7:4]}, a, 8'h0F, 4);
				bl = blend_channel({4'h0, f16[11:8]}, {4'h0, b16[11:8]}, a, 8'h0F, 4);
				return {16'h0, a[3:0], bl[3:0], g[3:0], r[3:0]};
			end
			default: begin
				a = fg[31:24];
				if (a == 8'h00) return bg;
				if (a == 8'hFF) return fg;
				r  = blend_channel(fg[7:0], bg[7:0], a, 8'hFF, 8);
				g  = blend_channel(fg[15:8], bg[15:8], a, 8'hFF, 8);
				bl = blend_channel(fg[23:16], bg[23:16], a, 8'hFF, 8);
				return {a, bl, g, r};
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			pixel_queue.delete();
			cur_fmt    <= FMT_8888;
			cur_blend  <= 1'b0;
			fail_total <= 0;
			pending    <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pixel_queue.size() == 0) begin
					$display("%0t: pixel_out beat with nothing expected, expected none, actual %08h",
						$time, pixel_out);
					fail_total <= fail_total + 1;
				end else begin
					want = pixel_queue.pop_front();
					if (pixel_out !== want) begin
						$display("%0t: pixel_out mismatch, expected %08h, actual %08h",
							$time, want, pixel_out);
						fail_total <= fail_total + 1;
					end
				end
			end
			if (in_valid && in_ready)
				pixel_queue.push_back(expected_pixel(cur_fmt, cur_blend, fg_color, bg_pixel));
			if (cfg_we) begin
				case (cfg_index)
					CFG_PIXEL_FORMAT: cur_fmt   <= pixel_fmt_t'(cfg_data[1:0]);
					CFG_BLEND_ENABLE: cur_blend <= cfg_data[0];
					default: ;
				endcase
			end
			pending <= pixel_queue.size();
		end
	end

endmodule

@@ tb/tb_pixel_format_alpha_blend_top.sv @@
// Testbench top: drives pixel beats with random gaps and config writes, and gives the verdict.
`timescale 1ns / 100ps

module tb_pixel_format_alpha_blend_top;
	import pfab_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 150;
	localparam int PHASES       = 16;
	localparam int PHASE_PIXELS = 40;
	localparam logic [7:0] ZERO_ALPHA [4] = '{8'h03, 8'h07, 8'h0F, 8'h00};
	localparam logic [7:0] FULL_ALPHA [4] = '{8'hFC, 8'hF8, 8'hF0, 8'hFF};

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	cfg_idx_t            cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [31:0]         fg_color;
	logic [31:0]         bg_pixel;
	logic                out_valid;
	logic                out_ready;
	logic [31:0]         pixel_out;
	int                  mismatches;
	int                  pending;
	int                  idle_cycles;
	bit                  send_calm;
	bit                  recv_calm;
	bit                  hold_req;

	pixel_format_alpha_blend_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.fg_color  (fg_color),
		.bg_pixel  (bg_pixel),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out)
	);

	pfab_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.fg_color   (fg_color),
		.bg_pixel   (bg_pixel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL pixel_format_alpha_blend_top");
				$finish;
			end
		end
	end

	task automatic configure(input pixel_fmt_t fmt, input logic [1:0] blend_data);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PIXEL_FORMAT;
		cfg_data  <= fmt;
		@(posedge clk);
		cfg_index <= CFG_BLEND_ENABLE;
		cfg_data  <= blend_data;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic send_pixel(input logic [31:0] fg, input logic [31:0] bg);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		fg_color <= fg;
		bg_pixel <= bg;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] random_fg(input pixel_fmt_t fmt);
		logic [7:0] alpha;
		case ($urandom_range(0, 3))
			0:       alpha = 8'($urandom_range(0, ZERO_ALPHA[fmt]));
			1:       alpha = 8'($urandom_range(FULL_ALPHA[fmt], 255));
			default: alpha = 8'($urandom_range(0, 255));
		endcase
		return {alpha, 24'($urandom)};
	endfunction

	// receiver: random stalls, calm stretches, one long hold-off on request
	initial begin
		int stall;
		out_ready <= 1'b0;
		recv_calm = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if ($urandom_range(0, 49) == 0)
				recv_calm = !recv_calm;
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end else begin
				stall = recv_calm ? 0 : $urandom_range(0, 17);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		pixel_fmt_t fmt;
		logic [1:0] blend_data;
		arst_n    = 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_PIXEL_FORMAT;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		fg_color  <= '0;
		bg_pixel  <= '0;
		send_calm = 1'b0;
		hold_req  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int f = 0; f < 4; f++) begin
			for (int b = 0; b < 2; b++) begin
				fmt = pixel_fmt_t'(f);
				configure(fmt, 2'(b));
				if (b == 0) begin
					send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
					send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
					send_pixel(32'h5A96_C33C, 32'hA569_3CC3);
				end else begin
					send_pixel({ZERO_ALPHA[f], 24'hFFFFFF}, 32'hC3A5_5A3C);
					send_pixel({FULL_ALPHA[f], 24'h12AB7F}, 32'hFFFF_FFFF);
					send_pixel(32'h80FF_00FF, 32'hFF00_FF00);
				end
				settle();
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			fmt        = pixel_fmt_t'($urandom_range(0, 3));
			blend_data = 2'($urandom_range(0, 3));
			configure(fmt, blend_data);
			if (p == 2) begin
				hold_req  = 1'b1;
				send_calm = 1'b1;
			end
			for (int i = 0; i < PHASE_PIXELS; i++)
				send_pixel(random_fg(fmt), $urandom);
			settle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("PASS pixel_format_alpha_blend_top");
		else
			$display("FAIL pixel_format_alpha_blend_top");
		$finish;
	end

endmodule
